/* hdl/best_fit_buffer_pool_core_defines.svh */
// Assertion macros for the buffer pool core.
// Used by best_fit_buffer_pool_core.sv; expects clk and arst_n in scope.
`ifndef BEST_FIT_BUFFER_POOL_CORE_DEFINES_SVH
`define BEST_FIT_BUFFER_POOL_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BFBP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BFBP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BFBP_ASSERT_IMP(lbl, ante, cons, msg)
`define BFBP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/bfbp_pkg.sv */
// Shared types and constants for the best-fit buffer pool.
// No dependencies.
package bfbp_pkg;

	localparam int unsigned SLOTS            = 8;
	localparam int unsigned NUM_BUFFERS_DEF  = 8;
	localparam int unsigned NUM_CHANNELS_DEF = 16;
	localparam int unsigned SIZE_W = 20;
	localparam int unsigned CHAN_W = 4;
	localparam int unsigned IDLE_W = 16;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned KIB    = 1024;

	localparam logic [SIZE_W-1:0] SIZE_RESET [SLOTS] = '{
		SIZE_W'(400 * KIB), SIZE_W'(200 * KIB), SIZE_W'(200 * KIB), SIZE_W'(100 * KIB),
		SIZE_W'(62 * KIB),  SIZE_W'(62 * KIB),  SIZE_W'(50 * KIB),  SIZE_W'(30 * KIB)
	};

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// item travelling down the row of cells
	typedef struct packed {
		logic              vld;
		logic              rel;
		logic              en;
		logic [CHAN_W-1:0] chan;
		logic [SIZE_W-1:0] req;
		logic [IDLE_W-1:0] idle;
		logic              hit;
		logic [SIZE_W-1:0] bsize;
		logic [IDX_W-1:0]  bidx;
		logic [SLOTS-1:0]  freed;
	} tok_t;

	typedef struct packed {
		logic              vld;
		logic [IDX_W-1:0]  idx;
		logic [CHAN_W-1:0] chan;
	} commit_t;

endpackage

/* hdl/bfbp_if.sv */
// Valid/ready channel interfaces for request and response items.
// Depends on bfbp_pkg.
interface bfbp_req_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [bfbp_pkg::CHAN_W-1:0]   channel;
	logic [bfbp_pkg::SIZE_W-1:0]   request_size;
	logic [bfbp_pkg::IDLE_W-1:0]   idle_mask;

	modport source (output valid, action, channel, request_size, idle_mask, input ready);
	modport sink   (input valid, action, channel, request_size, idle_mask, output ready);
endinterface

interface bfbp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          granted;
	logic [bfbp_pkg::IDX_W-1:0]    buffer_index;
	logic [bfbp_pkg::SLOTS-1:0]    freed_mask;

	modport source (output valid, granted, buffer_index, freed_mask, input ready);
	modport sink   (input valid, granted, buffer_index, freed_mask, output ready);
endinterface

/* hdl/best_fit_buffer_pool_core.sv */
// Best-fit buffer pool: one item in flight; the result is valid once the item, registered at
// acceptance, has walked the row of cells one cell per cycle and the result has then been
// registered; the next item is taken once the result has been handed over.
// Depends on bfbp_pkg, bfbp_if, bfbp_cell and best_fit_buffer_pool_core_defines.svh.
`include "best_fit_buffer_pool_core_defines.svh"

module best_fit_buffer_pool_core #(
	parameter int unsigned NUM_BUFFERS  = bfbp_pkg::NUM_BUFFERS_DEF,
	parameter int unsigned NUM_CHANNELS = bfbp_pkg::NUM_CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bfbp_req_if.sink                    req_ch,
	bfbp_rsp_if.source                  rsp_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bfbp_pkg::ADDR_W-1:0] paddr,
	input  logic [bfbp_pkg::DATA_W-1:0] pwdata,
	output logic [bfbp_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                      state_q;
	logic [bfbp_pkg::SIZE_W-1:0] size_q [bfbp_pkg::SLOTS];
	bfbp_pkg::tok_t              tok0_q;
	bfbp_pkg::tok_t              tok [NUM_BUFFERS+1];
	bfbp_pkg::tok_t              tok_last;
	bfbp_pkg::commit_t           commit;
	logic [NUM_BUFFERS-1:0]      owned_vec;
	logic [NUM_BUFFERS:0]        tok_vld;
	logic                        granted_q;
	logic [bfbp_pkg::IDX_W-1:0]  idx_q;
	logic [bfbp_pkg::SLOTS-1:0]  freed_q;
	logic                        accept;
	logic                        cfg_wr;
	logic [bfbp_pkg::IDX_W-1:0]  cfg_idx;

	// config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[bfbp_pkg::ADDR_W-1:2];
	assign prdata  = bfbp_pkg::DATA_W'(size_q[cfg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < bfbp_pkg::SLOTS; k++) begin
				size_q[k] <= bfbp_pkg::SIZE_RESET[k];
			end
		end else if (cfg_wr) begin
			size_q[cfg_idx] <= pwdata[bfbp_pkg::SIZE_W-1:0];
		end
	end

	// item entry
	assign req_ch.ready = (state_q == ST_IDLE);
	assign accept       = req_ch.valid && req_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q <= '0;
		end else begin
			tok0_q.vld   <= accept;
			tok0_q.rel   <= (req_ch.action == bfbp_pkg::ACT_RELEASE);
			tok0_q.en    <= (int'(req_ch.channel) < NUM_CHANNELS);
			tok0_q.chan  <= req_ch.channel;
			tok0_q.req   <= req_ch.request_size;
			tok0_q.idle  <= req_ch.idle_mask;
			tok0_q.hit   <= 1'b0;
			tok0_q.bsize <= '0;
			tok0_q.bidx  <= '0;
			tok0_q.freed <= '0;
		end
	end

	assign tok[0] = tok0_q;

	for (genvar k = 0; k < NUM_BUFFERS; k++) begin : g_cell
		bfbp_cell #(
			.CELL_IDX(k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.size   (size_q[k]),
			.commit (commit),
			.tok_i  (tok[k]),
			.tok_o  (tok[k+1]),
			.owned  (owned_vec[k])
		);
	end

	always_comb begin
		for (int k = 0; k <= NUM_BUFFERS; k++) begin
			tok_vld[k] = tok[k].vld;
		end
	end

	assign tok_last    = tok[NUM_BUFFERS];
	assign commit.vld  = tok_last.vld && !tok_last.rel && tok_last.hit;
	assign commit.idx  = tok_last.bidx;
	assign commit.chan = tok_last.chan;

	// sequencing and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok_last.vld) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tok_last.vld) begin
			granted_q <= commit.vld;
			idx_q     <= commit.vld ? tok_last.bidx : '0;
			freed_q   <= tok_last.rel ? tok_last.freed : '0;
		end
	end

	assign rsp_ch.valid        = (state_q == ST_DONE);
	assign rsp_ch.granted      = granted_q;
	assign rsp_ch.buffer_index = idx_q;
	assign rsp_ch.freed_mask   = freed_q;

	`BFBP_ASSERT_IMP(a_single_item, 1'b1, $onehot0(tok_vld), "more than one item in the row")
	`BFBP_ASSERT_NXT(a_grant_owns, commit.vld, $countones(owned_vec) == $past($countones(owned_vec)) + 1, "grant did not take ownership")
	`BFBP_ASSERT_IMP(a_done_empty, rsp_ch.valid, tok_vld == '0, "item still in row while result waits")
	`BFBP_ASSERT_IMP(a_grant_xor_free, rsp_ch.valid && rsp_ch.granted, rsp_ch.freed_mask == '0, "grant and release in one result")

endmodule

/* hdl/bfbp_cell.sv */
// One pool cell: ownership of a single buffer, best-fit compare and release.
// Depends on bfbp_pkg.
module bfbp_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bfbp_pkg::SIZE_W-1:0] size,
	input  bfbp_pkg::commit_t           commit,
	input  bfbp_pkg::tok_t              tok_i,
	output bfbp_pkg::tok_t              tok_o,
	output logic                        owned
);

	bfbp_pkg::tok_t              tok_q;
	bfbp_pkg::tok_t              tok_nxt;
	logic                        owned_q;
	logic [bfbp_pkg::CHAN_W-1:0] chan_q;
	logic                        fit;
	logic                        take;
	logic                        free_me;

	always_comb begin
		fit     = tok_i.vld && !tok_i.rel && tok_i.en && !owned_q
			&& (size != '0) && (size >= tok_i.req);
		take    = fit && (!tok_i.hit || (tok_i.bsize > size));
		free_me = tok_i.vld && tok_i.rel && owned_q && tok_i.idle[chan_q];
		tok_nxt = tok_i;
		if (take) begin
			tok_nxt.hit   = 1'b1;
			tok_nxt.bsize = size;
			tok_nxt.bidx  = bfbp_pkg::IDX_W'(CELL_IDX);
		end
		if (free_me) begin
			tok_nxt.freed[CELL_IDX] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			owned_q <= 1'b0;
			chan_q  <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (free_me) begin
				owned_q <= 1'b0;
			end else if (commit.vld && (commit.idx == bfbp_pkg::IDX_W'(CELL_IDX))) begin
				owned_q <= 1'b1;
				chan_q  <= commit.chan;
			end
		end
	end

	assign tok_o = tok_q;
	assign owned = owned_q;

endmodule
